### hdl/fqr_pkg.sv
package fqr_pkg;

  // Widths of the transaction fields
  localparam int IdFieldW = 16;
  localparam int OccW     = 5;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [IdFieldW-1:0] item_id;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [IdFieldW-1:0] head_id;
    logic [OccW-1:0]     occupancy;
    logic                is_empty;
  } rsp_t;

endpackage

### hdl/fqr_core.sv
module fqr_core import fqr_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic ready,
  output logic res_valid,
  input  logic res_take,
  output rsp_t res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  op_t                 op_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [ID_WIDTH-1:0] taken;
  status_t             status_r;
  logic [CW-1:0]       rd_idx;
  logic [AW-1:0]       d_idx;
  logic                dv;
  logic                found;
  logic [ID_WIDTH-1:0] rd_data;
  logic [ID_WIDTH-1:0] mem [DEPTH];

  logic [ID_WIDTH-1:0] id_in;
  logic                full;
  logic                rd_en;
  logic                hit;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ID_WIDTH-1:0] wr_data;

  // Mask the incoming identifier to the stored width
  assign id_in = ID_WIDTH'(req.item_id);
  assign full  = (count == CW'(DEPTH));

  // Walk reads one entry per cycle; read data is registered
  assign rd_en = (state == S_WALK) && (rd_idx < count);
  assign hit   = dv && !found && ((op_r == OP_DEQ) || (rd_data == id_r));

  // Single write port: enqueue at the tail, or pull an entry down one slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = id_in;
    if (state == S_IDLE) begin
      wr_en = start && (req.op == OP_ENQ) && !full;
    end else begin
      wr_en   = (state == S_WALK) && dv && found;
      wr_addr = d_idx - AW'(1);
      wr_data = rd_data;
    end
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  // Sequencer: one entry per cycle through the shared compare
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      dv       <= 1'b0;
      found    <= 1'b0;
      status_r <= ST_OK;
      taken    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r     <= req.op;
            id_r     <= id_in;
            rd_idx   <= '0;
            dv       <= 1'b0;
            found    <= 1'b0;
            taken    <= '0;
            status_r <= ST_OK;
            case (req.op)
              OP_ENQ: begin
                if (full) begin
                  status_r <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
                state <= S_DONE;
              end
              OP_DEQ, OP_REMOVE: begin
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_DONE;
                end else begin
                  state <= S_WALK;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_WALK: begin
          if (rd_en) begin
            d_idx  <= rd_idx[AW-1:0];
            rd_idx <= rd_idx + CW'(1);
            dv     <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          // Record the oldest match; only a dequeue reports the identifier
          if (hit) begin
            found <= 1'b1;
            taken <= (op_r == OP_DEQ) ? rd_data : '0;
          end
          // All entries seen and pulled down: close out
          if (!dv && (rd_idx == count)) begin
            if (found) begin
              count <= count - CW'(1);
            end else begin
              status_r <= ST_NOT_FOUND;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status    = status_r;
    res.head_id   = IdFieldW'(taken);
    res.occupancy = OccW'(count);
    res.is_empty  = (count == '0);
  end

endmodule

### hdl/fifo_queue_with_remove_by_id.sv
// First-come-first-served queue of identifiers, up to DEPTH entries held in a
// single-port-write, registered-read memory with the head at address 0. Each
// request transaction enqueues, dequeues, or removes the oldest entry equal to
// item_id, and gives exactly one response transaction with status, the
// dequeued identifier and the occupancy afterward. Enqueue, the unused opcode,
// and dequeue or remove on an empty queue go straight from acceptance to the
// response register. Dequeue and remove on a non-empty queue first walk every
// live entry through the memory read port, one entry per cycle, comparing each
// entry and moving every entry after the match down a slot as it goes.
// Requests are stalled while an operation is in flight; a finished response
// waits in the output register without holding up the next request.
module fifo_queue_with_remove_by_id import fqr_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic core_ready;
  logic start;
  logic res_valid;
  logic res_take;
  rsp_t res;

  assign req_stall = !core_ready;
  assign start     = req_valid && core_ready;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  fqr_core #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Hold the response until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule

### tb/fifo_queue_with_remove_by_id_test.sv
`timescale 1ns / 1ps

module fifo_queue_with_remove_by_id_test;
  import fqr_pkg::*;

  localparam int QueueDepth = 16;
  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 40;
  localparam int RandomPerPhase = 280;

  // Shadow of the identifier queue and the responses it still owes
  class queue_shadow;
    logic [IdFieldW-1:0] live_ids[$];
    rsp_t                owed_rsps[$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         op_count[4];
    int unsigned         status_count[4];
    int unsigned         peak_occupancy;

    function int unsigned pending();
      return owed_rsps.size();
    endfunction

    // Apply one accepted request transaction and queue its response
    function void note_request(req_t r);
      rsp_t want;
      int   pos;
      want = '0;
      want.status = ST_OK;
      pos = -1;
      op_count[int'(r.op)]++;
      case (r.op)
        OP_ENQ: begin
          if (live_ids.size() >= QueueDepth) want.status = ST_FULL;
          else live_ids.push_back(r.item_id);
        end
        OP_DEQ: begin
          if (live_ids.size() == 0) want.status = ST_EMPTY;
          else want.head_id = live_ids.pop_front();
        end
        OP_REMOVE: begin
          if (live_ids.size() == 0) begin
            want.status = ST_EMPTY;
          end else begin
            // oldest match only
            foreach (live_ids[i]) begin
              if (pos < 0 && live_ids[i] == r.item_id) pos = i;
            end
            if (pos < 0) want.status = ST_NOT_FOUND;
            else live_ids.delete(pos);
          end
        end
        default: ;
      endcase
      want.occupancy = OccW'(live_ids.size());
      want.is_empty  = (live_ids.size() == 0);
      status_count[int'(want.status)]++;
      if (live_ids.size() > peak_occupancy) peak_occupancy = live_ids.size();
      owed_rsps.push_back(want);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 20) $display("%0t ns  MISMATCH: %s", $time, msg);
    endtask

    // Compare one accepted response transaction with the oldest owed one
    task check_response(rsp_t got);
      rsp_t want;
      if (owed_rsps.size() == 0) begin
        report($sformatf("response 0x%h arrived with nothing pending", got));
        return;
      end
      want = owed_rsps.pop_front();
      checked++;
      if (got.status !== want.status)
        report($sformatf("response %0d status %0d, want %0d", checked, got.status,
                         want.status));
      if (got.head_id !== want.head_id)
        report($sformatf("response %0d head_id 0x%h, want 0x%h", checked, got.head_id,
                         want.head_id));
      if (got.occupancy !== want.occupancy)
        report($sformatf("response %0d occupancy %0d, want %0d", checked,
                         got.occupancy, want.occupancy));
      if (got.is_empty !== want.is_empty)
        report($sformatf("response %0d is_empty %b, want %b", checked, got.is_empty,
                         want.is_empty));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int req_idle_pct = 0;
  int rsp_stall_pct = 0;

  queue_shadow shadow;

  fifo_queue_with_remove_by_id #(
    .DEPTH    (QueueDepth),
    .ID_WIDTH (IdFieldW)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Randomly hold off the response channel
  always @(negedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < rsp_stall_pct);
  end

  // Track both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) shadow.note_request(req);
      if (rsp_valid && !rsp_stall) shadow.check_response(rsp);
    end
  end

  // End the run if no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", QuietLimit);
    $display("** fifo_queue_with_remove_by_id: FAILED **");
    $finish;
  end

  // Present one request and hold it until accepted
  task send_request(input op_t op, input logic [IdFieldW-1:0] id);
    req_t r;
    r.op = op;
    r.item_id = id;
    while ($urandom_range(99) < req_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
  endtask

  // Stop sending and wait for every owed response
  task drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Random traffic that swings the occupancy between empty and full
  task run_phase(input int idle_pct, input int stall_pct, input int n);
    logic [IdFieldW-1:0] pool[6];
    logic [IdFieldW-1:0] id;
    op_t                 op;
    int                  pick;
    bit                  grow;
    pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h1234, 16'h00FF};
    req_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      grow = ((i / 48) % 2) == 0;
      pick = $urandom_range(99);
      if (pick < 5) op = OP_NOP;
      else if (grow) op = (pick < 70) ? OP_ENQ : ((pick < 85) ? OP_DEQ : OP_REMOVE);
      else op = (pick < 25) ? OP_ENQ : ((pick < 62) ? OP_DEQ : OP_REMOVE);
      // half the time one of six recurring ids so duplicates build up
      if ($urandom_range(1) == 0) id = pool[$urandom_range(5)];
      else id = IdFieldW'($urandom_range(65535));
      // aim most removes at a live entry
      if (op == OP_REMOVE && shadow.live_ids.size() != 0 && $urandom_range(99) < 70)
        id = shadow.live_ids[$urandom_range(shadow.live_ids.size() - 1)];
      send_request(op, id);
    end
    drain();
  endtask

  initial begin
    shadow = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Empty queue: dequeue, remove and the unused opcode
    send_request(OP_DEQ, 16'hFFFF);
    send_request(OP_REMOVE, 16'h0000);
    send_request(OP_NOP, 16'hFFFF);
    // Extreme ids and a duplicate
    send_request(OP_ENQ, 16'h0000);
    send_request(OP_ENQ, 16'hFFFF);
    send_request(OP_ENQ, 16'h1234);
    send_request(OP_ENQ, 16'h5A5A);
    send_request(OP_ENQ, 16'h1234);
    send_request(OP_REMOVE, 16'h1234);
    send_request(OP_REMOVE, 16'h7777);
    send_request(OP_DEQ, 16'h0000);
    // Fill to the top, then one refused enqueue
    for (int k = 0; k < 14; k++) send_request(OP_ENQ, 16'h8000 | IdFieldW'(k));
    // Remove at the tail and at the head
    send_request(OP_REMOVE, 16'h800C);
    send_request(OP_REMOVE, 16'hFFFF);
    drain();

    run_phase(0, 0, RandomPerPhase);
    run_phase(60, 0, RandomPerPhase);
    run_phase(0, 60, RandomPerPhase);
    run_phase(8, 8, RandomPerPhase);

    rsp_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d requests: %0d enqueue, %0d dequeue, %0d remove, %0d no-op; %0d checked",
             shadow.op_count[0] + shadow.op_count[1] + shadow.op_count[2] +
             shadow.op_count[3], shadow.op_count[0], shadow.op_count[1],
             shadow.op_count[2], shadow.op_count[3], shadow.checked);
    $display("Statuses: ok %0d, empty %0d, not found %0d, full %0d; peak occupancy %0d",
             shadow.status_count[0], shadow.status_count[1], shadow.status_count[2],
             shadow.status_count[3], shadow.peak_occupancy);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("** fifo_queue_with_remove_by_id: PASSED **");
    end else begin
      $display("%0d mismatches, %0d responses missing", shadow.mismatches,
               shadow.pending());
      $display("** fifo_queue_with_remove_by_id: FAILED **");
    end
    $finish;
  end

endmodule

### fifo_queue_with_remove_by_id.f
hdl/fqr_pkg.sv
hdl/fqr_core.sv
hdl/fifo_queue_with_remove_by_id.sv
tb/fifo_queue_with_remove_by_id_test.sv
